### rtl/core/wtrs_pkg.sv
// Shared codes, state and command types for the wavelet tree rank/select core.
`timescale 1ns / 1ps

package wtrs_pkg;

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_APPEND = 3'd1;
  localparam logic [2:0] OP_BUILD  = 3'd2;
  localparam logic [2:0] OP_ACCESS = 3'd3;
  localparam logic [2:0] OP_RANK   = 3'd4;
  localparam logic [2:0] OP_SELECT = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_NOT_READY = 2'd3;

  localparam logic REG_SYMBOL_BITS = 1'b0;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_FINISH,
    S_B_CLR, S_B_HST0, S_B_HST1, S_B_HST2, S_B_SC0, S_B_SC1, S_B_INI,
    S_B_IN0, S_B_IN1, S_B_PL0, S_B_PL1, S_B_PL2, S_B_PL3,
    S_Q_RD, S_Q_UP, S_Q_SEL, S_F_RD, S_F_UP, S_Q_RES
  } state_t;

  typedef enum logic [4:0] {
    C_NOP, C_LOAD, C_FAIL, C_CLEAR, C_APPEND,
    C_B_INIT, C_B_CLR, C_H_SYM, C_H_CUR, C_H_WR,
    C_SC_INIT, C_SC_RD, C_SC_WR, C_IN_INIT, C_IN_RD, C_IN_WR,
    C_PL_INIT, C_PL_SYM, C_PL_LOAD, C_PL_RD, C_PL_WR, C_B_DONE,
    C_Q_INIT, C_SCAN_RD, C_SCAN_UP, C_LVL_END,
    C_SEL_INIT, C_F_RD, C_F_UP, C_F_HIT, C_Q_RES, C_EMIT
  } cmd_e_t;

  typedef struct packed {
    cmd_e_t     cmd;
    logic [1:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       built;
    logic       full;
    logic       qpos_bad;
    logic       nth_zero;
    logic       j_last;
    logic       j_zero;
    logic       i_eq_len;
    logic       i_eq_s;
    logic       l_last;
    logic       l_zero;
    logic       s_lt_nth;
    logic       i_eq_ps;
    logic       f_hit;
    logic       out_free;
  } dp_stat_t;

endpackage

### rtl/core/wtrs_ctrl.sv
// Sequencer that steps the datapath through build and query walks.
`timescale 1ns / 1ps

module wtrs_ctrl
  import wtrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.cmd   = C_NOP;
    cmd.code  = ST_OK;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cmd   = C_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_FINISH;
        unique case (stat.op) inside
          OP_CLEAR: cmd.cmd = C_CLEAR;
          OP_APPEND: begin
            if (stat.full) begin
              cmd.cmd  = C_FAIL;
              cmd.code = ST_NOT_READY;
            end else begin
              cmd.cmd = C_APPEND;
            end
          end
          OP_BUILD: begin
            cmd.cmd   = C_B_INIT;
            state_nxt = S_B_CLR;
          end
          OP_ACCESS, OP_RANK, OP_SELECT: begin
            if (!stat.built) begin
              cmd.cmd  = C_FAIL;
              cmd.code = ST_NOT_READY;
            end else if ((stat.op != OP_SELECT && stat.qpos_bad) ||
                         (stat.op == OP_SELECT && stat.nth_zero)) begin
              cmd.cmd  = C_FAIL;
              cmd.code = ST_RANGE;
            end else begin
              cmd.cmd   = C_Q_INIT;
              state_nxt = S_Q_RD;
            end
          end
          default: state_nxt = S_IDLE;  // unused codes: drop silently
        endcase
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.cmd   = C_EMIT;
          state_nxt = S_IDLE;
        end
      end
      S_B_CLR: begin
        cmd.cmd = C_B_CLR;
        if (stat.j_last) state_nxt = S_B_HST0;
      end
      S_B_HST0: begin
        if (stat.i_eq_len) begin
          cmd.cmd   = C_SC_INIT;
          state_nxt = S_B_SC0;
        end else begin
          cmd.cmd   = C_H_SYM;
          state_nxt = S_B_HST1;
        end
      end
      S_B_HST1: begin
        cmd.cmd   = C_H_CUR;
        state_nxt = S_B_HST2;
      end
      S_B_HST2: begin
        cmd.cmd   = C_H_WR;
        state_nxt = S_B_HST0;
      end
      S_B_SC0: begin
        cmd.cmd   = C_SC_RD;
        state_nxt = S_B_SC1;
      end
      S_B_SC1: begin
        cmd.cmd   = C_SC_WR;
        state_nxt = stat.j_last ? S_B_INI : S_B_SC0;
      end
      S_B_INI: begin
        cmd.cmd   = C_IN_INIT;
        state_nxt = S_B_IN0;
      end
      S_B_IN0: begin
        if (stat.j_zero) begin
          cmd.cmd   = C_PL_INIT;
          state_nxt = S_B_PL0;
        end else begin
          cmd.cmd   = C_IN_RD;
          state_nxt = S_B_IN1;
        end
      end
      S_B_IN1: begin
        cmd.cmd   = C_IN_WR;
        state_nxt = S_B_IN0;
      end
      S_B_PL0: begin
        if (stat.i_eq_len) begin
          cmd.cmd   = C_B_DONE;
          state_nxt = S_FINISH;
        end else begin
          cmd.cmd   = C_PL_SYM;
          state_nxt = S_B_PL1;
        end
      end
      S_B_PL1: begin
        cmd.cmd   = C_PL_LOAD;
        state_nxt = S_B_PL2;
      end
      S_B_PL2: begin
        cmd.cmd   = C_PL_RD;
        state_nxt = S_B_PL3;
      end
      S_B_PL3: begin
        cmd.cmd   = C_PL_WR;
        state_nxt = stat.l_last ? S_B_PL0 : S_B_PL2;
      end
      S_Q_RD: begin
        if (stat.i_eq_s) begin
          cmd.cmd = C_LVL_END;
          if (stat.l_last) begin
            state_nxt = (stat.op == OP_SELECT) ? S_Q_SEL : S_Q_RES;
          end
        end else begin
          cmd.cmd   = C_SCAN_RD;
          state_nxt = S_Q_UP;
        end
      end
      S_Q_UP: begin
        cmd.cmd   = C_SCAN_UP;
        state_nxt = S_Q_RD;
      end
      S_Q_SEL: begin
        if (stat.s_lt_nth) begin
          cmd.cmd   = C_FAIL;
          cmd.code  = ST_NOT_FOUND;
          state_nxt = S_FINISH;
        end else begin
          cmd.cmd   = C_SEL_INIT;
          state_nxt = S_F_RD;
        end
      end
      S_F_RD: begin
        if (stat.i_eq_ps) begin
          cmd.cmd   = C_FAIL;
          cmd.code  = ST_NOT_FOUND;
          state_nxt = S_FINISH;
        end else begin
          cmd.cmd   = C_F_RD;
          state_nxt = S_F_UP;
        end
      end
      S_F_UP: begin
        if (stat.f_hit) begin
          cmd.cmd   = C_F_HIT;
          state_nxt = stat.l_zero ? S_Q_RES : S_F_RD;
        end else begin
          cmd.cmd   = C_F_UP;
          state_nxt = S_F_RD;
        end
      end
      S_Q_RES: begin
        cmd.cmd   = C_Q_RES;
        state_nxt = S_FINISH;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### rtl/core/wtrs_dp.sv
// Datapath: symbol store, level bitmap, node cursors, walk registers, result register.
`timescale 1ns / 1ps

module wtrs_dp
  import wtrs_pkg::*;
#(
  parameter int MAX_LENGTH      = 4096,
  parameter int MAX_SYMBOL_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [39:0] in_tdata,
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata
);

  localparam int LW  = $clog2(MAX_LENGTH + 1);
  localparam int PW  = $clog2(MAX_LENGTH);
  localparam int JW  = MAX_SYMBOL_BITS + 1;
  localparam int CD  = 2 ** JW;
  localparam int LD  = MAX_SYMBOL_BITS * MAX_LENGTH;
  localparam int LAW = $clog2(LD);
  localparam int CW  = ((LW > 13) ? LW : 13) + 1;
  localparam int LVW = (MAX_SYMBOL_BITS > 1) ? $clog2(MAX_SYMBOL_BITS) : 1;
  localparam logic [3:0] K_RESET = (MAX_SYMBOL_BITS < 8) ? 4'(MAX_SYMBOL_BITS) : 4'd8;

  function automatic logic [LAW-1:0] lvl_addr(input logic [3:0] lv, input logic [PW-1:0] pos);
    return LAW'(int'(lv) * MAX_LENGTH + int'(pos));
  endfunction

  // memories
  logic [7:0]    sym_mem [MAX_LENGTH];
  logic [LW-1:0] cur_mem [CD];
  logic          lvl_mem [LD];

  logic [7:0]    sym_rd_r;
  logic [LW-1:0] cur_rd_r;
  logic          lvl_rd_r;

  // control registers
  logic [3:0]    k_r;
  logic [LW-1:0] len_r;
  logic          built_r;
  logic          out_valid_r;

  // walk registers
  logic [2:0]    op_r;
  logic [7:0]    sym_r;
  logic [11:0]   qpos_r;
  logic [12:0]   nth_r;
  logic [LW-1:0] i_r, b_r, s_r, c_r, z_r, zp_r, acc_r;
  logic [JW-1:0] j_r;
  logic [3:0]    l_r;
  logic [MAX_SYMBOL_BITS-1:0] res_r;
  logic          lastbit_r;
  logic [CW-1:0] want_r;
  logic [7:0]    plsym_r;
  logic [LW-1:0] pb_r [MAX_SYMBOL_BITS];
  logic [LW-1:0] ps_r [MAX_SYMBOL_BITS];
  logic [12:0]   res_val_r, out_val_r;
  logic [1:0]    res_st_r, out_st_r;

  logic [JW-1:0] a_w, leaf;
  logic [JW:0]   two_a;
  logic [LVW-1:0] li;
  logic [3:0]    bidx;
  logic [15:0]   sym_ext, pl_ext;
  logic          qbit, plbit, lvl_bit;
  logic          cfg_we;
  logic [3:0]    cfg_k;

  logic          sym_we, sym_re, cur_we, cur_re, lvl_we, lvl_re;
  logic [PW-1:0] sym_ra;
  logic [JW-1:0] cur_wa, cur_ra;
  logic [LW-1:0] cur_wd;
  logic [LAW-1:0] lvl_wa, lvl_ra;

  assign a_w     = JW'(1) << k_r;
  assign two_a   = (JW + 1)'(1) << k_r;
  assign leaf    = a_w | (JW'(sym_rd_r) & (a_w - JW'(1)));
  assign li      = LVW'(l_r);
  assign bidx    = k_r - 4'd1 - l_r;
  assign sym_ext = {8'd0, sym_r};
  assign pl_ext  = {8'd0, plsym_r};
  assign qbit    = sym_ext[bidx];
  assign plbit   = pl_ext[bidx];
  assign lvl_bit = (op_r == OP_ACCESS) ? lastbit_r : qbit;

  assign cfg_we = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_SYMBOL_BITS);
  always_comb begin
    cfg_k = cfg_pwdata[3:0];
    if (cfg_k == 4'd0) cfg_k = 4'd1;
    if (int'(cfg_k) > MAX_SYMBOL_BITS) cfg_k = 4'(MAX_SYMBOL_BITS);
  end
  assign cfg_prdata = {28'd0, k_r};

  // status to the sequencer
  always_comb begin
    stat.op       = op_r;
    stat.built    = built_r;
    stat.full     = (len_r == LW'(MAX_LENGTH));
    stat.qpos_bad = (CW'(qpos_r) >= CW'(len_r));
    stat.nth_zero = (nth_r == 13'd0);
    stat.j_last   = (j_r == JW'(two_a - (JW + 1)'(1)));
    stat.j_zero   = (j_r == JW'(0));
    stat.i_eq_len = (i_r == len_r);
    stat.i_eq_s   = (i_r == s_r);
    stat.l_last   = (l_r == k_r - 4'd1);
    stat.l_zero   = (l_r == 4'd0);
    stat.s_lt_nth = (CW'(s_r) < CW'(nth_r));
    stat.i_eq_ps  = (i_r == ps_r[li]);
    stat.f_hit    = (lvl_rd_r == qbit) && (CW'(zp_r) + CW'(1) == want_r);
    stat.out_free = !out_valid_r || out_tready;
  end

  // memory port decode
  always_comb begin
    sym_we = (cmd.cmd == C_APPEND);
    sym_re = (cmd.cmd == C_H_SYM) || (cmd.cmd == C_PL_SYM);
    sym_ra = PW'(i_r);
    cur_we = 1'b0;
    cur_wa = j_r;
    cur_wd = '0;
    cur_re = 1'b0;
    cur_ra = j_r;
    lvl_we = (cmd.cmd == C_PL_WR);
    lvl_wa = lvl_addr(l_r, PW'(cur_rd_r));
    lvl_re = (cmd.cmd == C_SCAN_RD) || (cmd.cmd == C_F_RD);
    lvl_ra = (cmd.cmd == C_F_RD) ? lvl_addr(l_r, PW'(pb_r[li] + i_r))
                                 : lvl_addr(l_r, PW'(b_r + i_r));
    unique case (cmd.cmd) inside
      C_B_CLR: cur_we = 1'b1;
      C_H_CUR: begin
        cur_re = 1'b1;
        cur_ra = leaf;
      end
      C_H_WR, C_PL_WR: begin
        cur_we = 1'b1;
        cur_wd = cur_rd_r + LW'(1);
      end
      C_SC_RD, C_PL_RD: cur_re = 1'b1;
      C_SC_WR: begin
        cur_we = 1'b1;
        cur_wd = acc_r;
      end
      C_IN_RD: begin
        cur_re = 1'b1;
        cur_ra = JW'({j_r, 1'b0});
      end
      C_IN_WR: begin
        cur_we = 1'b1;
        cur_wd = cur_rd_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sym_we) sym_mem[PW'(len_r)] <= sym_r;
    if (sym_re) sym_rd_r <= sym_mem[sym_ra];
  end

  always_ff @(posedge clk) begin
    if (cur_we) cur_mem[cur_wa] <= cur_wd;
    if (cur_re) cur_rd_r <= cur_mem[cur_ra];
  end

  always_ff @(posedge clk) begin
    if (lvl_we) lvl_mem[lvl_wa] <= plbit;
    if (lvl_re) lvl_rd_r <= lvl_mem[lvl_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= K_RESET;
      len_r       <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        k_r     <= cfg_k;
        built_r <= 1'b0;
      end
      case (cmd.cmd)
        C_CLEAR: begin
          len_r   <= '0;
          built_r <= 1'b0;
        end
        C_APPEND: begin
          len_r   <= len_r + LW'(1);
          built_r <= 1'b0;
        end
        C_B_DONE: built_r <= 1'b1;
        default: ;
      endcase
      if (cmd.cmd == C_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    case (cmd.cmd) inside
      C_LOAD: begin
        op_r   <= in_tuser;
        sym_r  <= in_tdata[7:0];
        qpos_r <= in_tdata[19:8];
        nth_r  <= in_tdata[32:20];
      end
      C_FAIL: begin
        res_val_r <= '0;
        res_st_r  <= cmd.code;
      end
      C_CLEAR, C_APPEND, C_B_DONE: begin
        res_val_r <= '0;
        res_st_r  <= ST_OK;
      end
      C_B_INIT: begin
        j_r <= a_w;
        i_r <= '0;
      end
      C_B_CLR: j_r <= j_r + JW'(1);
      C_H_CUR: j_r <= leaf;
      C_H_WR: i_r <= i_r + LW'(1);
      C_SC_INIT: begin
        j_r   <= a_w;
        acc_r <= '0;
      end
      C_SC_WR: begin
        acc_r <= acc_r + cur_rd_r;
        j_r   <= j_r + JW'(1);
      end
      C_IN_INIT: j_r <= a_w - JW'(1);
      C_IN_WR: j_r <= j_r - JW'(1);
      C_PL_INIT: i_r <= '0;
      C_PL_LOAD: begin
        plsym_r <= sym_rd_r;
        j_r     <= JW'(1);
        l_r     <= 4'd0;
      end
      C_PL_WR: begin
        j_r <= JW'({j_r, plbit});
        l_r <= l_r + 4'd1;
        if (l_r == k_r - 4'd1) i_r <= i_r + LW'(1);
      end
      C_Q_INIT: begin
        b_r   <= '0;
        s_r   <= len_r;
        c_r   <= (op_r == OP_SELECT) ? LW'(0) : LW'(qpos_r) + LW'(1);
        l_r   <= 4'd0;
        i_r   <= '0;
        z_r   <= '0;
        zp_r  <= '0;
        res_r <= '0;
      end
      C_SCAN_UP: begin
        if (!lvl_rd_r) z_r <= z_r + LW'(1);
        if (i_r < c_r && !lvl_rd_r) zp_r <= zp_r + LW'(1);
        if (i_r == c_r - LW'(1)) lastbit_r <= lvl_rd_r;
        i_r <= i_r + LW'(1);
      end
      C_LVL_END: begin
        res_r     <= MAX_SYMBOL_BITS'({res_r, lvl_bit});
        c_r       <= lvl_bit ? c_r - zp_r : zp_r;
        pb_r[li]  <= b_r;
        ps_r[li]  <= s_r;
        if (lvl_bit) begin
          b_r <= b_r + z_r;
          s_r <= s_r - z_r;
        end else begin
          s_r <= z_r;
        end
        l_r  <= l_r + 4'd1;
        i_r  <= '0;
        z_r  <= '0;
        zp_r <= '0;
      end
      C_SEL_INIT: begin
        l_r    <= k_r - 4'd1;
        want_r <= CW'(nth_r);
        i_r    <= '0;
        zp_r   <= '0;
      end
      C_F_UP: begin
        if (lvl_rd_r == qbit) zp_r <= zp_r + LW'(1);
        i_r <= i_r + LW'(1);
      end
      C_F_HIT: begin
        c_r    <= i_r;
        want_r <= CW'(i_r) + CW'(1);
        i_r    <= '0;
        zp_r   <= '0;
        l_r    <= l_r - 4'd1;
      end
      C_Q_RES: begin
        res_val_r <= (op_r == OP_ACCESS) ? 13'(res_r) : 13'(c_r);
        res_st_r  <= ST_OK;
      end
      C_EMIT: begin
        out_val_r <= res_val_r;
        out_st_r  <= res_st_r;
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_st_r, out_val_r};

endmodule

### rtl/core/wavelet_tree_rank_select_core.sv
// Top level of the wavelet tree access/rank/select core.
`timescale 1ns / 1ps

// Wavelet tree over an appended symbol sequence (up to MAX_LENGTH symbols of
// symbol_bits bits, register at address 0). One request at a time. Build
// clears the node cursors, counts the symbols into the leaves, turns the
// counts into node offsets by a prefix scan, fills the inner nodes from
// their left children and then places each symbol's bits in the level
// bitmap. Access and rank scan each visited node of the level bitmap bit by
// bit; select adds a second bottom-up scan of the same nodes. The bitmap and
// cursor memories are each read with a registered output. A result waits in
// the output register while the next request is taken.
module wavelet_tree_rank_select_core
  import wtrs_pkg::*;
#(
  parameter int MAX_LENGTH      = 4096,
  parameter int MAX_SYMBOL_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // symbol_in[7:0], query_pos[19:8], occurrence[32:20]
  input  logic [2:0]  in_tuser,    // op[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // result_value[12:0], status[14:13]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_pready = 1'b1;

  wtrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wtrs_dp #(
    .MAX_LENGTH      (MAX_LENGTH),
    .MAX_SYMBOL_BITS (MAX_SYMBOL_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata)
  );

endmodule

### dv/tb_top.sv
// Self-checking testbench for the wavelet tree access/rank/select core.
`timescale 1ns / 1ps

module tb_top;
  import wtrs_pkg::*;

  localparam int MAX_LEN = 4096;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  sym;
    logic [11:0] pos;
    logic [12:0] occ;
  } request_t;

  typedef struct {
    logic [12:0] value;
    logic [1:0]  status;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  wavelet_tree_rank_select_core dut (.*);

  // testbench copy of the core state
  logic [7:0] sym_mem [MAX_LEN];
  int         seq_len = 0;
  bit         tree_built = 0;
  int         sym_width = 8;

  request_t   req_q[$];
  answer_t    answer_q[$];
  request_t   cur_req;
  int         idle_pct;
  int         stall_pct;
  bit         pressure_armed;
  bit         pressure_done;
  int         hold_left;
  int         err_cnt = 0;
  int         req_cnt = 0;
  int         ans_cnt = 0;
  int         in_stall_cnt = 0;
  int         op_seen [8] = '{default: 0};

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #1s;
    $display("tb_top: errors");
    $finish;
  end

  // Work out the answer one request produces, updating the copied state.
  function automatic bit predict_answer(request_t r, output answer_t a);
    logic [7:0] msk;
    int         hits;
    msk = 8'((1 << sym_width) - 1);
    a.value = '0;
    a.status = ST_OK;
    case (r.op)
      OP_CLEAR: begin
        seq_len = 0;
        tree_built = 0;
      end
      OP_APPEND: begin
        if (seq_len >= MAX_LEN) begin
          a.status = ST_NOT_READY;
        end else begin
          sym_mem[seq_len] = r.sym;
          seq_len++;
          tree_built = 0;
        end
      end
      OP_BUILD: tree_built = 1;
      OP_ACCESS, OP_RANK, OP_SELECT: begin
        if (!tree_built) begin
          a.status = ST_NOT_READY;
        end else if (r.op == OP_ACCESS) begin
          if (r.pos >= seq_len) a.status = ST_RANGE;
          else a.value = 13'(sym_mem[r.pos] & msk);
        end else if (r.op == OP_RANK) begin
          if (r.pos >= seq_len) begin
            a.status = ST_RANGE;
          end else begin
            hits = 0;
            for (int i = 0; i <= r.pos; i++)
              if ((sym_mem[i] & msk) == (r.sym & msk)) hits++;
            a.value = 13'(hits);
          end
        end else if (r.occ == 0) begin
          a.status = ST_RANGE;
        end else begin
          hits = 0;
          a.status = ST_NOT_FOUND;
          for (int i = 0; i < seq_len; i++) begin
            if ((sym_mem[i] & msk) == (r.sym & msk)) begin
              hits++;
              if (hits == r.occ && a.status != ST_OK) begin
                a.status = ST_OK;
                a.value = 13'(i);
              end
            end
          end
        end
      end
      default: return 0;
    endcase
    return 1;
  endfunction

  // sender
  always @(posedge clk) begin
    answer_t a;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        req_cnt++;
        op_seen[cur_req.op]++;
        if (predict_answer(cur_req, a)) answer_q.push_back(a);
      end
      if (in_tvalid && !in_tready) in_stall_cnt++;
      if (!in_tvalid || in_tready) begin
        if (req_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur_req = req_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_req.op;
          in_tdata <= {7'b0, cur_req.occ, cur_req.pos, cur_req.sym};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off when armed
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
      pressure_done <= 1'b0;
    end else if (pressure_armed && !pressure_done && out_tvalid) begin
      hold_left <= 400;
      pressure_done <= 1'b1;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    answer_t a;
    if (rst_n && out_tvalid && out_tready) begin
      ans_cnt++;
      if (answer_q.size() == 0) begin
        $error("unexpected result value=%0d status=%0d", out_tdata[12:0], out_tdata[14:13]);
        err_cnt++;
      end else begin
        a = answer_q.pop_front();
        if (out_tdata[12:0] !== a.value) begin
          $error("result_value expected %0d got %0d", a.value, out_tdata[12:0]);
          err_cnt++;
        end
        if (out_tdata[14:13] !== a.status) begin
          $error("status expected %0d got %0d", a.status, out_tdata[14:13]);
          err_cnt++;
        end
      end
    end
  end

  task automatic push_req(logic [2:0] op, logic [7:0] sym = 0, logic [11:0] pos = 0,
                          logic [12:0] occ = 0);
    request_t r;
    r.op = op;
    r.sym = sym;
    r.pos = pos;
    r.occ = occ;
    req_q.push_back(r);
  endtask

  // hold until every request is taken and answered, then let the core settle
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (req_q.size() > 0 || in_tvalid || answer_q.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_sym_width(int v);
    logic [31:0] wd;
    wd = {16'($urandom_range(16'hFFFF)), 12'($urandom), 4'(v)};
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(4 * REG_SYMBOL_BITS);
    cfg_pwdata <= wd;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sym_width = (v < 1) ? 1 : (v > 8) ? 8 : v;
    tree_built = 0;
  endtask

  task automatic pick_query(int n);
    int          sel;
    logic [7:0]  s;
    logic [11:0] p;
    logic [12:0] o;
    sel = $urandom_range(2);
    s = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range((1 << sym_width) - 1));
    if (n > 0 && $urandom_range(4) != 0) s = sym_mem[$urandom_range(n - 1)];
    p = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(n + 1));
    o = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(n / 2 + 2));
    push_req(sel == 0 ? OP_ACCESS : sel == 1 ? OP_RANK : OP_SELECT, s, p, o);
  endtask

  // clear, fill, build, query sessions with some noise mixed in
  task automatic add_sessions(int total);
    int n;
    int cnt;
    int start;
    start = req_q.size();
    while (req_q.size() - start < total) begin
      if ($urandom_range(7) != 0) push_req(OP_CLEAR);
      n = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(1, 20);
      for (int i = 0; i < n; i++) begin
        push_req(OP_APPEND, 8'($urandom));
        if ($urandom_range(29) == 0)
          push_req(3'($urandom), 8'($urandom), 12'($urandom), 13'($urandom));
      end
      if ($urandom_range(9) == 0) pick_query(n);
      if ($urandom_range(11) != 0) push_req(OP_BUILD);
      cnt = $urandom_range(3, 12);
      for (int i = 0; i < cnt; i++) pick_query(n);
    end
  endtask

  initial begin
    int widths [8];
    widths = '{8, 1, 0, 15, 3, 5, 2, 7};
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    idle_pct = 0;
    stall_pct = 0;
    pressure_armed = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: edge symbols, unused codes and the query error checks at full width
    push_req(OP_ACCESS);
    push_req(OP_RANK);
    push_req(OP_SELECT, 0, 0, 1);
    push_req(3'd6, 8'hFF, 12'hFFF, 13'h1FFF);
    push_req(3'd7);
    push_req(OP_CLEAR);
    push_req(OP_APPEND, 8'h00);
    push_req(OP_APPEND, 8'hFF);
    push_req(OP_APPEND, 8'h80);
    push_req(OP_APPEND, 8'h7F);
    push_req(OP_APPEND, 8'hFF);
    push_req(OP_BUILD);
    push_req(OP_ACCESS, 0, 0);
    push_req(OP_ACCESS, 0, 4);
    push_req(OP_ACCESS, 0, 5);
    push_req(OP_RANK, 8'hFF, 4);
    push_req(OP_RANK, 8'h00, 0);
    push_req(OP_RANK, 8'h00, 12'hFFF);
    push_req(OP_SELECT, 8'hFF, 0, 0);
    push_req(OP_SELECT, 8'hFF, 0, 2);
    push_req(OP_SELECT, 8'hFF, 0, 3);
    push_req(OP_SELECT, 8'h00, 0, 13'h1000);
    push_req(OP_APPEND, 8'h01);
    push_req(OP_ACCESS, 0, 0);
    drain();

    // full store at one bit per symbol, plus one append too many
    write_sym_width(1);
    push_req(OP_CLEAR);
    for (int i = 0; i < MAX_LEN; i++) push_req(OP_APPEND, 8'($urandom));
    push_req(OP_APPEND, 8'h01);
    push_req(OP_BUILD);
    push_req(OP_ACCESS, 0, 12'hFFF);
    push_req(OP_RANK, 8'h01, 12'hFFF);
    push_req(OP_SELECT, 8'h00, 0, 1);
    push_req(OP_SELECT, 8'h03, 0, 13'h1000);
    drain();

    // random phases over widths and flow-control mixes
    for (int ph = 0; ph < 8; ph++) begin
      write_sym_width(widths[ph]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      pressure_armed = (ph == 4);
      add_sessions(250);
      drain();
    end

    $display("covered %0d requests, %0d results, input stalled %0d cycles", req_cnt,
             ans_cnt, in_stall_cnt);
    $display("ops clear/append/build/access/rank/select/unused: %0d %0d %0d %0d %0d %0d %0d",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5],
             op_seen[6] + op_seen[7]);
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
